### rtl/rlt_pkg.sv
// ----------------------------------------------------------------------------
// rlt_pkg
// Shared types, sizes and helpers for the replica lock table.
// ----------------------------------------------------------------------------
package rlt_pkg;

   localparam int LOCK_SLOTS = 64;
   localparam int SLOT_W     = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;
   localparam int CNT_W      = $clog2(LOCK_SLOTS + 1);

   localparam logic [3:0] MAX_REPLICAS = 4'd8;

   // request kinds
   localparam logic REQ_LOCK   = 1'b0;
   localparam logic REQ_UNLOCK = 1'b1;

   typedef enum logic [2:0] {
      ST_GRANTED = 3'd0,
      ST_RETRY   = 3'd1,
      ST_HELD    = 3'd2,
      ST_FREED   = 3'd3,
      ST_FULL    = 3'd4,
      ST_BAD     = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

   // One table slot as kept in the RAM. A slot is owned exactly while its
   // release count is nonzero.
   typedef struct packed {
      logic [31:0] lock_address;
      logic [31:0] owner;
      logic [31:0] held_epoch;
      logic [3:0]  release_count;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

   // Low six bits of a slot number, zero-extended for narrow tables.
   function automatic logic [5:0] slot_field(logic [SLOT_W-1:0] slot);
      logic [SLOT_W+5:0] wide;
      wide = {6'b0, slot};
      return wide[5:0];
   endfunction

   // Clamp the replica register into 1..8.
   function automatic logic [3:0] effective_replicas(logic [3:0] value);
      logic [3:0] eff;
      if (value == 4'd0) begin
         eff = 4'd1;
      end else if (value > MAX_REPLICAS) begin
         eff = MAX_REPLICAS;
      end else begin
         eff = value;
      end
      return eff;
   endfunction

endpackage

### rtl/rlt_ram.sv
// ----------------------------------------------------------------------------
// rlt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rlt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/replica_lock_table_unit.sv
// ----------------------------------------------------------------------------
// replica_lock_table_unit
// Lock table shared by replicated threads: grant, retry and release of locks.
// ----------------------------------------------------------------------------
// One item is handled at a time: an accept step reads slot 0, then the
// single read port of the slot RAM walks the used slots from slot 0, one
// slot per cycle, up to a match or the end-of-table check, and the result
// is registered before it is loaded into the output register.
// Slots are claimed in order and never freed, so a fill count marks the used
// slots; no clearing pass runs after reset and items are taken right away.
// A result waiting in the output register does not block the next accept.
// ----------------------------------------------------------------------------
module replica_lock_table_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [31:0] req_lock_address,
   input  logic [31:0] req_thread_id,
   input  logic [31:0] req_epoch,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_slot_index,
   output logic [3:0]  rsp_remaining_count,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_replica_count
);

   import rlt_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] scan_next;
   logic [3:0]       replica_ff;

   logic             kind_ff;
   logic [31:0]      addr_ff, tid_ff, ep_ff;

   status_type       res_status_ff, res_status_in;
   logic [5:0]       res_slot_ff, res_slot_in;
   logic [3:0]       res_remain_ff, res_remain_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff;
   logic [5:0]       rsp_slot_ff;
   logic [3:0]       rsp_remain_ff;

   logic             req_accept;
   logic             rsp_load;
   logic             in_used, hit, table_end, table_full;
   logic [3:0]       eff, count_dec;
   slot_entry_type   entry, wr_entry;
   logic             wr_en, rd_en;
   logic [SLOT_W-1:0] wr_addr, rd_addr;
   logic [ENTRY_W-1:0] rd_data;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   assign scan_next  = scan_ff + CNT_W'(1);
   assign entry      = slot_entry_type'(rd_data);
   assign in_used    = (scan_ff < fill_ff);
   assign hit        = in_used && (entry.lock_address == addr_ff);
   assign table_end  = !in_used;
   assign table_full = (fill_ff == CNT_W'(LOCK_SLOTS));
   assign eff        = effective_replicas(replica_ff);
   assign count_dec  = entry.release_count - 4'd1;

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      fill_in       = fill_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_remain_in = res_remain_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = scan_ff[SLOT_W-1:0];
      wr_entry      = entry;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               rd_en    = 1'b1;
               rd_addr  = '0;
               scan_in  = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (hit) begin
               state_in    = S_DONE;
               res_slot_in = slot_field(scan_ff[SLOT_W-1:0]);
               if (kind_ff == REQ_LOCK) begin
                  if (entry.release_count == 4'd0) begin
                     wr_en                  = 1'b1;
                     wr_entry.owner         = tid_ff;
                     wr_entry.held_epoch    = ep_ff;
                     wr_entry.release_count = eff;
                     res_status_in          = ST_GRANTED;
                     res_remain_in          = eff;
                  end else if (entry.owner == tid_ff && entry.held_epoch == ep_ff) begin
                     res_status_in = ST_GRANTED;
                     res_remain_in = entry.release_count;
                  end else begin
                     res_status_in = ST_RETRY;
                     res_remain_in = entry.release_count;
                  end
               end else begin
                  if (entry.release_count == 4'd0) begin
                     res_status_in = ST_BAD;
                     res_remain_in = 4'd0;
                  end else begin
                     wr_en                  = 1'b1;
                     wr_entry.release_count = count_dec;
                     res_remain_in          = count_dec;
                     res_status_in          = (count_dec == 4'd0) ? ST_FREED : ST_HELD;
                  end
               end
            end else if (table_end) begin
               state_in      = S_DONE;
               res_slot_in   = 6'd0;
               res_remain_in = 4'd0;
               if (kind_ff == REQ_UNLOCK) begin
                  res_status_in = ST_BAD;
               end else if (table_full) begin
                  res_status_in = ST_FULL;
               end else begin
                  // claim the first unused slot and grant it at once
                  wr_en         = 1'b1;
                  wr_addr       = fill_ff[SLOT_W-1:0];
                  wr_entry      = '{lock_address:  addr_ff,
                                    owner:         tid_ff,
                                    held_epoch:    ep_ff,
                                    release_count: eff};
                  fill_in       = fill_ff + CNT_W'(1);
                  res_status_in = ST_GRANTED;
                  res_slot_in   = slot_field(fill_ff[SLOT_W-1:0]);
                  res_remain_in = eff;
               end
            end else begin
               // advance to the next used slot
               rd_en   = 1'b1;
               rd_addr = scan_next[SLOT_W-1:0];
               scan_in = scan_next;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   rlt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (LOCK_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scan_ff      <= '0;
         fill_ff      <= '0;
         replica_ff   <= 4'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            replica_ff <= csr_replica_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff <= req_type;
         addr_ff <= req_lock_address;
         tid_ff  <= req_thread_id;
         ep_ff   <= req_epoch;
      end
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_remain_ff <= res_remain_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_remain_ff <= res_remain_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_slot_index      = rsp_slot_ff;
   assign rsp_remaining_count = rsp_remain_ff;

   // the fill count only grows by one, and only at the end of a scan
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (fill_ff != $past(fill_ff)) |->
         (fill_ff == $past(fill_ff) + CNT_W'(1)) && ($past(state_ff) == S_SCAN))
      else $error("fill count changed outside a claim");

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> (state_ff == S_SCAN))
      else $error("accepted item did not start a scan");

   a_result_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready) |=>
         rsp_valid_ff && (state_ff == S_IDLE))
      else $error("finished item not handed to the output register");

   a_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_SCAN) && (hit || table_end))
      else $error("slot RAM written outside the end of a scan");

endmodule
